[hw/rtl/periodic_task_dispatcher_top_macros.svh]
// Assertion macros shared by the periodic task dispatcher RTL.
`ifndef PERIODIC_TASK_DISPATCHER_TOP_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define PTD_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PTD_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PTD_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons, msg)
`define PTD_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons, msg)

`endif

`endif

[hw/rtl/ptd_pkg.sv]
// Package with the types, codes and sizes of the periodic task dispatcher.
`default_nettype none

package ptd_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int ACTION_W  = 2;
	localparam int SLOT_W    = 3;
	localparam int PERIOD_W  = 16;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(PERIOD_W + 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK   = 2'd0,
		ACT_CREATE = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_TAKEN = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic req_ready;
		logic take_req;
		logic div_start;
		logic mark_due;
		logic idx_next;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_valid;
		logic req_tick;
		logic out_free;
		logic slot_live;
		logic idx_last;
		logic div_done;
		logic mask_final;
	} stat_t;

endpackage

`default_nettype wire

[hw/rtl/ptd_if.sv]
// Request and response channel interfaces of the periodic task dispatcher.
`default_nettype none

interface ptd_req_if;
	logic                          valid;
	logic                          ready;
	logic [ptd_pkg::ACTION_W-1:0]  action;
	logic [ptd_pkg::SLOT_W-1:0]    slot;
	logic [ptd_pkg::PERIOD_W-1:0]  period;

	modport source (output valid, action, slot, period, input ready);
	modport sink   (input valid, action, slot, period, output ready);
endinterface

interface ptd_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        fire;
	logic [ptd_pkg::SLOT_W-1:0]  task_id;
	logic                        status;
	logic                        last;

	modport source (output valid, fire, task_id, status, last, input ready);
	modport sink   (input valid, fire, task_id, status, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/ptd_mod.sv]
// Iterative restoring remainder unit: one quotient bit per cycle.
`default_nettype none
`include "periodic_task_dispatcher_top_macros.svh"

module ptd_mod (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [ptd_pkg::PERIOD_W-1:0] dividend,
	input  wire logic [ptd_pkg::PERIOD_W-1:0] divisor,
	output logic                              busy,
	output logic                              done,
	output logic                              rem_zero
);

	logic                         busy_q;
	logic                         done_q;
	logic [ptd_pkg::CNT_W-1:0]    cnt_q;
	logic [ptd_pkg::PERIOD_W-1:0] rem_q;
	logic [ptd_pkg::PERIOD_W-1:0] dvd_q;
	logic [ptd_pkg::PERIOD_W-1:0] dsr_q;
	logic [ptd_pkg::PERIOD_W:0]   trial;
	logic [ptd_pkg::PERIOD_W:0]   diff;
	logic [ptd_pkg::PERIOD_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[ptd_pkg::PERIOD_W-1]};
		diff    = trial - {1'b0, dsr_q};
		rem_nxt = (trial >= {1'b0, dsr_q}) ? diff[ptd_pkg::PERIOD_W-1:0]
		                                   : trial[ptd_pkg::PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ptd_pkg::CNT_W'(ptd_pkg::PERIOD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ptd_pkg::CNT_W'(1);
				if (cnt_q == ptd_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[ptd_pkg::PERIOD_W-2:0], 1'b0};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

	`PTD_ASSERT_IMP(a_start_idle, clk, arst_n, start, !busy_q, "remainder unit restarted while busy")

endmodule

`default_nettype wire

[hw/rtl/ptd_datapath.sv]
// Datapath: slot table, tick counter, due mask, remainder unit and result register.
`default_nettype none
`include "periodic_task_dispatcher_top_macros.svh"

module ptd_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ptd_pkg::cmd_t  cmd,
	output ptd_pkg::stat_t      stat,
	ptd_req_if.sink             req,
	ptd_rsp_if.source           rsp
);

	logic [ptd_pkg::PERIOD_W-1:0]  tick_count_q;
	logic [ptd_pkg::PERIOD_W-1:0]  task_period_q [ptd_pkg::NUM_SLOTS];
	logic [ptd_pkg::NUM_SLOTS-1:0] slot_valid_q;
	logic [ptd_pkg::IDX_W-1:0]     idx_q;
	logic [ptd_pkg::NUM_SLOTS-1:0] due_mask_q;

	logic                          out_valid_q;
	logic                          out_fire_q;
	logic [ptd_pkg::SLOT_W-1:0]    out_task_id_q;
	logic                          out_status_q;
	logic                          out_last_q;

	logic [ptd_pkg::IDX_W-1:0]     req_idx;
	logic                          slot_in_range;
	logic                          create_ok;
	logic [ptd_pkg::IDX_W-1:0]     low_id;
	logic [ptd_pkg::NUM_SLOTS-1:0] mask_rest;
	logic                          out_free;
	logic                          div_busy;
	logic                          div_done;
	logic                          div_rem_zero;

	assign req_idx       = req.slot[ptd_pkg::IDX_W-1:0];
	assign slot_in_range = int'(req.slot) < ptd_pkg::NUM_SLOTS;
	assign create_ok     = slot_in_range && !slot_valid_q[req_idx];
	assign out_free      = !out_valid_q || rsp.ready;

	// Lowest due slot and the mask left once it has been reported.
	always_comb begin
		low_id = '0;
		for (int i = ptd_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (due_mask_q[i]) begin
				low_id = ptd_pkg::IDX_W'(i);
			end
		end
		mask_rest = due_mask_q & (due_mask_q - ptd_pkg::NUM_SLOTS'(1));
	end

	ptd_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (tick_count_q),
		.divisor  (task_period_q[idx_q]),
		.busy     (div_busy),
		.done     (div_done),
		.rem_zero (div_rem_zero)
	);

	always_comb begin
		stat.req_valid  = req.valid;
		stat.req_tick   = (req.action == ptd_pkg::ACT_TICK);
		stat.out_free   = out_free;
		stat.slot_live  = slot_valid_q[idx_q] && (task_period_q[idx_q] != '0);
		stat.idx_last   = (int'(idx_q) == ptd_pkg::NUM_SLOTS - 1);
		stat.div_done   = div_done;
		stat.mask_final = (mask_rest == '0);
	end

	// Control state: tick counter, valid bits, walk index, due mask, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			slot_valid_q <= '0;
			idx_q        <= '0;
			due_mask_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.take_req) begin
				unique case (req.action)
					ptd_pkg::ACT_TICK: begin
						tick_count_q <= tick_count_q + ptd_pkg::PERIOD_W'(1);
						idx_q        <= '0;
						due_mask_q   <= '0;
					end
					ptd_pkg::ACT_CREATE: begin
						out_valid_q <= 1'b1;
						if (create_ok) begin
							slot_valid_q[req_idx] <= 1'b1;
						end
					end
					ptd_pkg::ACT_DELETE: begin
						out_valid_q <= 1'b1;
						if (slot_in_range) begin
							slot_valid_q[req_idx] <= 1'b0;
						end
					end
					default: begin
						out_valid_q <= 1'b1;
					end
				endcase
			end
			if (cmd.mark_due && div_rem_zero) begin
				due_mask_q[idx_q] <= 1'b1;
			end
			if (cmd.idx_next) begin
				idx_q <= idx_q + ptd_pkg::IDX_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				due_mask_q  <= mask_rest;
			end
		end
	end

	// Payload: stored periods and the result fields.
	always_ff @(posedge clk) begin
		if (cmd.take_req && req.action == ptd_pkg::ACT_CREATE && create_ok) begin
			task_period_q[req_idx] <= req.period;
		end
		if (cmd.take_req) begin
			out_fire_q <= 1'b0;
			out_last_q <= 1'b1;
			unique case (req.action)
				ptd_pkg::ACT_CREATE: begin
					out_task_id_q <= req.slot;
					out_status_q  <= create_ok ? ptd_pkg::STATUS_OK : ptd_pkg::STATUS_TAKEN;
				end
				ptd_pkg::ACT_DELETE: begin
					out_task_id_q <= req.slot;
					out_status_q  <= ptd_pkg::STATUS_OK;
				end
				default: begin
					out_task_id_q <= '0;
					out_status_q  <= ptd_pkg::STATUS_OK;
				end
			endcase
		end else if (cmd.emit) begin
			out_fire_q    <= (due_mask_q != '0);
			out_task_id_q <= ptd_pkg::SLOT_W'(low_id);
			out_status_q  <= ptd_pkg::STATUS_OK;
			out_last_q    <= (mask_rest == '0);
		end
	end

	assign req.ready   = cmd.req_ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.fire    = out_fire_q;
	assign rsp.task_id = out_task_id_q;
	assign rsp.status  = out_status_q;
	assign rsp.last    = out_last_q;

	`PTD_ASSERT_NXT(a_more_due, clk, arst_n, cmd.emit && !stat.mask_final, due_mask_q != '0, "due mask emptied before the last result")
	`PTD_ASSERT_IMP(a_no_mark_busy, clk, arst_n, cmd.mark_due, !div_busy, "due mark taken while remainder unit busy")

endmodule

`default_nettype wire

[hw/rtl/ptd_ctrl.sv]
// Controller state machine: request intake, slot walk and result emission.
`default_nettype none
`include "periodic_task_dispatcher_top_macros.svh"

module ptd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ptd_pkg::stat_t stat,
	output ptd_pkg::cmd_t       cmd
);

	ptd_pkg::state_t state_q;
	ptd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ptd_pkg::S_IDLE: begin
				cmd.req_ready = stat.out_free;
				if (stat.req_valid && stat.out_free) begin
					cmd.take_req = 1'b1;
					if (stat.req_tick) begin
						state_d = ptd_pkg::S_SCAN;
					end
				end
			end
			ptd_pkg::S_SCAN: begin
				if (stat.slot_live) begin
					cmd.div_start = 1'b1;
					state_d       = ptd_pkg::S_DIV;
				end else if (stat.idx_last) begin
					state_d = ptd_pkg::S_EMIT;
				end else begin
					cmd.idx_next = 1'b1;
				end
			end
			ptd_pkg::S_DIV: begin
				if (stat.div_done) begin
					cmd.mark_due = 1'b1;
					if (stat.idx_last) begin
						state_d = ptd_pkg::S_EMIT;
					end else begin
						cmd.idx_next = 1'b1;
						state_d      = ptd_pkg::S_SCAN;
					end
				end
			end
			ptd_pkg::S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.mask_final) begin
						state_d = ptd_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = ptd_pkg::S_IDLE;
			end
		endcase
	end

	`PTD_ASSERT_IMP(a_ready_idle, clk, arst_n, cmd.req_ready, state_q == ptd_pkg::S_IDLE, "request taken outside idle")
	`PTD_ASSERT_NXT(a_div_exit, clk, arst_n, state_q == ptd_pkg::S_DIV && stat.div_done, state_q == ptd_pkg::S_SCAN || state_q == ptd_pkg::S_EMIT, "walk stuck after remainder")

endmodule

`default_nettype wire

[hw/rtl/periodic_task_dispatcher_top.sv]
// Top level of the periodic task dispatcher: controller, datapath and channels.
`default_nettype none

// The dispatcher keeps eight task slots, indexed by priority, each with a valid
// bit and a 16-bit period, and a 16-bit wrapping tick counter. A request
// transaction carries an action (0 tick, 1 create, 2 delete), a slot and a
// period. Create and delete each give one response transaction with fire clear,
// task_id equal to the requested slot and last set; create on a slot already in
// use is refused with status 1 and leaves the slot as it was. An unused action
// code changes nothing and answers with all fields zero but last. A tick first
// advances the counter, then walks all slots in ascending order and gives one
// response with fire set for each valid slot whose nonzero period divides the
// new count, last marking the final one; when no slot is due it gives a single
// response with fire clear. Create, delete and unused actions are taken one per
// cycle as long as the response register is free or being drained. A tick
// passes over each empty or zero-period slot, and for each live slot starts the
// bit-serial remainder unit, waits through its 16 shift steps and then reads the
// remainder, the periods being tested one after another. After the walk it
// writes its responses in turn; no new request is taken until the last one has
// been written. The response sits in an output register, so a stalled consumer
// holds the block only once the next response is ready to be written. There is
// no configuration port and no clearing pass.
module periodic_task_dispatcher_top (
	input  wire logic clk,
	input  wire logic arst_n,
	ptd_req_if.sink   req,
	ptd_rsp_if.source rsp
);

	// Command and status groups between the state machine and the datapath.
	ptd_pkg::cmd_t  cmd;
	ptd_pkg::stat_t stat;

	ptd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// The datapath owns both channels: it drives ready from the controller's
	// command and holds the response register.
	ptd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
